/* hw/rtl/frame_buffer_pool_manager_unit_macros.svh */
`ifndef FRAME_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH
`define FRAME_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH

// same-cycle implication
`define FBPM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame buffer pool check failed");

// next-cycle implication
`define FBPM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame buffer pool check failed");

`endif

/* hw/rtl/fbpm_pkg.sv */
package fbpm_pkg;

    localparam int OP_W       = 2;
    localparam int ID_IN_W    = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int RES_W      = 3;
    localparam int SIZE_W     = 27;
    localparam int OFFSET_W   = 31;

    typedef enum logic [OP_W-1:0] {
        OP_FILL   = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2
    } op_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESOLUTION  = 2'd1;

    localparam logic [RES_W-1:0] RES_1080P = 3'd0;
    localparam logic [RES_W-1:0] RES_720P  = 3'd1;
    localparam logic [RES_W-1:0] RES_4K    = 3'd2;
    localparam logic [RES_W-1:0] RES_8K    = 3'd3;

    // bytes per frame, 32-aligned width times 32-aligned height times 3
    function automatic logic [SIZE_W-1:0] frame_size(input logic [RES_W-1:0] res);
        logic [SIZE_W-1:0] size;
        unique case (res)
            RES_1080P: size = 27'd6266880;
            RES_720P:  size = 27'd2826240;
            RES_4K:    size = 27'd25067520;
            RES_8K:    size = 27'd99532800;
            default:   size = '0;
        endcase
        return size;
    endfunction

endpackage

/* hw/rtl/frame_buffer_pool_manager_unit.sv */
// Frame buffer pool manager. Buffers move between a free FIFO, a ready FIFO
// and a held set: fill (operation 0) with s_fill_ok set queues the oldest
// free buffer as ready, or overwrites the newest ready one when nothing is
// free and more than one is ready; lock (1) moves the oldest ready buffer to
// held; unlock (2) returns a held buffer to the free FIFO. Every beat yields
// one result beat with the buffer index and its byte offset (index times frame
// size). The block takes one beat per cycle while m_ready is high. The list
// update is registered into the decision stage, the offset multiply into the
// offset stage, whose registers present the result beat. Input stalls only
// when both stages hold a beat and m_ready is low.
// Writing frame_count (index 0) clamps it to 1..MAX_BUFFERS and restarts the
// pool with all buffers free; resolution (index 1) changes the frame size.
// Write the registers only while no beat is in flight.
module frame_buffer_pool_manager_unit #(
    parameter int MAX_BUFFERS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fbpm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fbpm_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fbpm_pkg::OP_W-1:0]           s_operation,
    input  logic                                s_fill_ok,
    input  logic [fbpm_pkg::ID_IN_W-1:0]        s_buffer_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_status,
    output logic [fbpm_pkg::ID_IN_W-1:0]        m_result_buffer,
    output logic [fbpm_pkg::OFFSET_W-1:0]       m_buffer_offset,
    output logic                                m_overwrote
);

    `include "frame_buffer_pool_manager_unit_macros.svh"

    localparam int ID_W        = $clog2(MAX_BUFFERS);
    localparam int CW          = $clog2(MAX_BUFFERS + 1);
    localparam int BW          = (ID_W > fbpm_pkg::ID_IN_W) ? ID_W : fbpm_pkg::ID_IN_W;
    localparam int PROD_W      = ID_W + fbpm_pkg::SIZE_W;
    localparam int RESET_COUNT = (MAX_BUFFERS < 3) ? MAX_BUFFERS : 3;

    function automatic logic [ID_W-1:0] ring_inc(input logic [ID_W-1:0] p);
        logic [ID_W-1:0] r;
        if (int'(p) == MAX_BUFFERS - 1) begin
            r = '0;
        end else begin
            r = p + ID_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] ring_add(input logic [ID_W-1:0] p,
                                                 input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(p) + (CW+1)'(n);
        if (int'(s) >= MAX_BUFFERS) begin
            s = s - (CW+1)'(MAX_BUFFERS);
        end
        return s[ID_W-1:0];
    endfunction

    logic [ID_W-1:0]            free_ring_reg [MAX_BUFFERS];
    logic [ID_W-1:0]            ready_ring_reg [MAX_BUFFERS];
    logic [CW-1:0]              frame_count_reg;
    logic [fbpm_pkg::RES_W-1:0] resolution_reg;
    logic [ID_W-1:0]            free_head_reg, free_head_next;
    logic [CW-1:0]              free_count_reg, free_count_next;
    logic [ID_W-1:0]            ready_head_reg, ready_head_next;
    logic [CW-1:0]              ready_count_reg, ready_count_next;
    logic [ID_W-1:0]            newest_reg, newest_next;
    logic [MAX_BUFFERS-1:0]     held_mask_reg, held_mask_next;

    logic                       free_we;
    logic [ID_W-1:0]            free_waddr;
    logic [ID_W-1:0]            free_wdata;
    logic                       ready_we;
    logic [ID_W-1:0]            ready_waddr;

    logic                       p1_valid_reg;
    logic                       p1_status_reg, p1_status_next;
    logic                       p1_over_reg, p1_over_next;
    logic [ID_W-1:0]            p1_buf_reg, p1_buf_next;

    logic                       out_valid_reg;
    logic                       out_status_reg;
    logic                       out_over_reg;
    logic [fbpm_pkg::ID_IN_W-1:0] out_buf_reg;
    logic [fbpm_pkg::OFFSET_W-1:0] out_offset_reg;

    logic                       accept;
    logic                       p1_adv;
    logic [CW-1:0]              cfg_count;
    logic [BW-1:0]              id_ext;
    logic [ID_W-1:0]            id_idx;
    logic                       id_in_pool;
    logic [BW-1:0]              buf_ext;
    logic [PROD_W-1:0]          product;
    logic [fbpm_pkg::SIZE_W-1:0] size;

    assign p1_adv  = !out_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_count = CW'(1);
        end else if (int'(cfg_wr_data) > MAX_BUFFERS) begin
            cfg_count = CW'(MAX_BUFFERS);
        end else begin
            cfg_count = CW'(cfg_wr_data);
        end
    end

    assign id_ext     = BW'(s_buffer_id);
    assign id_idx     = id_ext[ID_W-1:0];
    assign id_in_pool = 8'(s_buffer_id) < 8'(frame_count_reg);

    always_comb begin
        free_head_next   = free_head_reg;
        free_count_next  = free_count_reg;
        ready_head_next  = ready_head_reg;
        ready_count_next = ready_count_reg;
        newest_next      = newest_reg;
        held_mask_next   = held_mask_reg;
        free_we          = 1'b0;
        free_waddr       = ring_add(free_head_reg, free_count_reg);
        free_wdata       = id_idx;
        ready_we         = 1'b0;
        ready_waddr      = ring_add(ready_head_reg, ready_count_reg);
        p1_status_next   = 1'b1;
        p1_over_next     = 1'b0;
        p1_buf_next      = '0;
        unique case (s_operation)
            fbpm_pkg::OP_FILL: begin
                if (free_count_reg != '0) begin
                    if (s_fill_ok) begin
                        p1_buf_next      = free_ring_reg[free_head_reg];
                        p1_status_next   = 1'b0;
                        free_head_next   = ring_inc(free_head_reg);
                        free_count_next  = free_count_reg - CW'(1);
                        ready_we         = 1'b1;
                        ready_count_next = ready_count_reg + CW'(1);
                        newest_next      = free_ring_reg[free_head_reg];
                    end
                end else if (ready_count_reg > CW'(1) && s_fill_ok) begin
                    p1_buf_next    = newest_reg;
                    p1_over_next   = 1'b1;
                    p1_status_next = 1'b0;
                end
            end
            fbpm_pkg::OP_LOCK: begin
                if (ready_count_reg != '0) begin
                    p1_buf_next      = ready_ring_reg[ready_head_reg];
                    p1_status_next   = 1'b0;
                    ready_head_next  = ring_inc(ready_head_reg);
                    ready_count_next = ready_count_reg - CW'(1);
                    held_mask_next[ready_ring_reg[ready_head_reg]] = 1'b1;
                end
            end
            fbpm_pkg::OP_UNLOCK: begin
                if (id_in_pool && held_mask_reg[id_idx]
                    && int'(free_count_reg) < MAX_BUFFERS) begin
                    held_mask_next[id_idx] = 1'b0;
                    free_we         = 1'b1;
                    free_count_next = free_count_reg + CW'(1);
                    p1_buf_next     = id_idx;
                    p1_status_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= CW'(RESET_COUNT);
            free_head_reg   <= '0;
            free_count_reg  <= CW'(RESET_COUNT);
            ready_head_reg  <= '0;
            ready_count_reg <= '0;
            newest_reg      <= '0;
            held_mask_reg   <= '0;
            for (int i = 0; i < MAX_BUFFERS; i++) begin
                free_ring_reg[i] <= (i < RESET_COUNT) ? ID_W'(i) : '0;
            end
        end else if (cfg_wr_en && cfg_addr == fbpm_pkg::CFG_FRAME_COUNT) begin
            frame_count_reg <= cfg_count;
            free_head_reg   <= '0;
            free_count_reg  <= cfg_count;
            ready_head_reg  <= '0;
            ready_count_reg <= '0;
            newest_reg      <= '0;
            held_mask_reg   <= '0;
            for (int i = 0; i < MAX_BUFFERS; i++) begin
                free_ring_reg[i] <= (CW'(i) < cfg_count) ? ID_W'(i) : '0;
            end
        end else if (accept) begin
            free_head_reg   <= free_head_next;
            free_count_reg  <= free_count_next;
            ready_head_reg  <= ready_head_next;
            ready_count_reg <= ready_count_next;
            newest_reg      <= newest_next;
            held_mask_reg   <= held_mask_next;
            if (free_we) begin
                free_ring_reg[free_waddr] <= free_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ready_we) begin
            ready_ring_reg[ready_waddr] <= newest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resolution_reg <= fbpm_pkg::RES_1080P;
        end else if (cfg_wr_en && cfg_addr == fbpm_pkg::CFG_RESOLUTION) begin
            resolution_reg <= cfg_wr_data[fbpm_pkg::RES_W-1:0];
        end
    end

    // decision stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg <= p1_status_next;
            p1_over_reg   <= p1_over_next;
            p1_buf_reg    <= p1_buf_next;
        end
    end

    // offset stage
    assign size    = fbpm_pkg::frame_size(resolution_reg);
    assign product = PROD_W'(p1_buf_reg) * PROD_W'(size);
    assign buf_ext = BW'(p1_buf_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_valid_reg && p1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg && p1_adv) begin
            out_status_reg <= p1_status_reg;
            out_over_reg   <= p1_over_reg;
            out_buf_reg    <= buf_ext[fbpm_pkg::ID_IN_W-1:0];
            out_offset_reg <= fbpm_pkg::OFFSET_W'(product);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_overwrote     = out_over_reg;
    assign m_result_buffer = out_buf_reg;
    assign m_buffer_offset = out_offset_reg;

    // every buffer of the pool sits in exactly one list
    `FBPM_ASSERT_NOW(a_pool_conserved, aclk, aresetn, 1'b1,
        (int'(free_count_reg) + int'(ready_count_reg) + $countones(held_mask_reg))
        == int'(frame_count_reg))
    `FBPM_ASSERT_NOW(a_refused_zero, aclk, aresetn, m_valid && m_status,
        m_result_buffer == '0 && m_buffer_offset == '0 && !m_overwrote)
    `FBPM_ASSERT_NEXT(a_lock_empty_refused, aclk, aresetn,
        accept && !cfg_wr_en && s_operation == fbpm_pkg::OP_LOCK && ready_count_reg == '0,
        p1_valid_reg && p1_status_reg)

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 128;
    localparam logic [fbpm_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [fbpm_pkg::OP_W-1:0]    op;
        logic                         fill_ok;
        logic [fbpm_pkg::ID_IN_W-1:0] buffer_id;
    } pool_request_t;

    typedef struct packed {
        logic                          status;
        logic [fbpm_pkg::ID_IN_W-1:0]  slot;
        logic [fbpm_pkg::OFFSET_W-1:0] offset;
        logic                          overwrote;
    } pool_answer_t;

    typedef struct packed {
        logic [4:0]                                   frame_cnt;
        logic [fbpm_pkg::RES_W-1:0]                   res;
        logic [POOL_SLOTS-1:0][fbpm_pkg::ID_IN_W-1:0] free_ring;
        logic [fbpm_pkg::ID_IN_W-1:0]                 free_hd;
        logic [4:0]                                   free_cnt;
        logic [POOL_SLOTS-1:0][fbpm_pkg::ID_IN_W-1:0] ready_ring;
        logic [fbpm_pkg::ID_IN_W-1:0]                 ready_hd;
        logic [4:0]                                   ready_cnt;
        logic [POOL_SLOTS-1:0]                        held;
    } pool_state_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [fbpm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [fbpm_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [fbpm_pkg::OP_W-1:0]       s_operation = '0;
    logic                            s_fill_ok = 1'b0;
    logic [fbpm_pkg::ID_IN_W-1:0]    s_buffer_id = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_status;
    logic [fbpm_pkg::ID_IN_W-1:0]    m_result_buffer;
    logic [fbpm_pkg::OFFSET_W-1:0]   m_buffer_offset;
    logic                            m_overwrote;

    pool_request_t request_queue[$];
    pool_answer_t  due_answers[$];
    pool_state_t   plan_state;
    pool_state_t   live_state;
    pool_request_t taken_req;
    pool_answer_t  predicted;
    pool_answer_t  oldest_due;
    int            send_idle_pct = 25;
    int            recv_stall_pct = 50;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    frame_buffer_pool_manager_unit #(
        .MAX_BUFFERS(POOL_SLOTS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_fill_ok      (s_fill_ok),
        .s_buffer_id    (s_buffer_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_buffer(m_result_buffer),
        .m_buffer_offset(m_buffer_offset),
        .m_overwrote    (m_overwrote)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // aligned width times aligned height times three bytes
    function automatic longint unsigned bytes_per_frame(
        input logic [fbpm_pkg::RES_W-1:0] res);
        case (res)
            fbpm_pkg::RES_1080P: return 64'd1920 * 64'd1088 * 64'd3;
            fbpm_pkg::RES_720P:  return 64'd1280 * 64'd736 * 64'd3;
            fbpm_pkg::RES_4K:    return 64'd3840 * 64'd2176 * 64'd3;
            fbpm_pkg::RES_8K:    return 64'd7680 * 64'd4320 * 64'd3;
            default:             return 64'd0;
        endcase
    endfunction

    task automatic refill_lists(inout pool_state_t st);
        for (int i = 0; i < POOL_SLOTS; i++) begin
            st.free_ring[i] = (i < st.frame_cnt) ? fbpm_pkg::ID_IN_W'(i) : '0;
        end
        st.free_hd = '0;
        st.free_cnt = st.frame_cnt;
        st.ready_ring = '0;
        st.ready_hd = '0;
        st.ready_cnt = '0;
        st.held = '0;
    endtask

    task automatic apply_register(inout pool_state_t st,
                                  input logic [fbpm_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [fbpm_pkg::CFG_DATA_W-1:0] data);
        if (addr == fbpm_pkg::CFG_FRAME_COUNT) begin
            if (data == 0) begin
                st.frame_cnt = 5'd1;
            end else if (data > POOL_SLOTS) begin
                st.frame_cnt = 5'(POOL_SLOTS);
            end else begin
                st.frame_cnt = data;
            end
            refill_lists(st);
        end else if (addr == fbpm_pkg::CFG_RESOLUTION) begin
            st.res = data[fbpm_pkg::RES_W-1:0];
        end
    endtask

    task automatic apply_pool_op(inout pool_state_t st, input pool_request_t r,
                                 output pool_answer_t ans);
        logic [fbpm_pkg::ID_IN_W-1:0] slot;
        logic [fbpm_pkg::ID_IN_W-1:0] idx;
        logic                         done;
        logic                         over;
        slot = '0;
        done = 1'b0;
        over = 1'b0;
        case (r.op)
            fbpm_pkg::OP_FILL: begin
                if (st.free_cnt > 0) begin
                    if (r.fill_ok) begin
                        slot = st.free_ring[st.free_hd];
                        st.free_hd = st.free_hd + 1'b1;
                        st.free_cnt = st.free_cnt - 1'b1;
                        idx = st.ready_hd + st.ready_cnt[fbpm_pkg::ID_IN_W-1:0];
                        st.ready_ring[idx] = slot;
                        st.ready_cnt = st.ready_cnt + 1'b1;
                        done = 1'b1;
                    end
                end else if (st.ready_cnt > 1) begin
                    if (r.fill_ok) begin
                        idx = st.ready_hd + st.ready_cnt[fbpm_pkg::ID_IN_W-1:0] - 1'b1;
                        slot = st.ready_ring[idx];
                        over = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            fbpm_pkg::OP_LOCK: begin
                if (st.ready_cnt > 0) begin
                    slot = st.ready_ring[st.ready_hd];
                    st.ready_hd = st.ready_hd + 1'b1;
                    st.ready_cnt = st.ready_cnt - 1'b1;
                    st.held[slot] = 1'b1;
                    done = 1'b1;
                end
            end
            fbpm_pkg::OP_UNLOCK: begin
                if (r.buffer_id < st.frame_cnt && st.held[r.buffer_id]
                    && st.free_cnt < POOL_SLOTS) begin
                    st.held[r.buffer_id] = 1'b0;
                    idx = st.free_hd + st.free_cnt[fbpm_pkg::ID_IN_W-1:0];
                    st.free_ring[idx] = r.buffer_id;
                    st.free_cnt = st.free_cnt + 1'b1;
                    slot = r.buffer_id;
                    done = 1'b1;
                end
            end
            default: ;
        endcase
        ans.status = !done;
        ans.slot = done ? slot : '0;
        ans.offset = done ? fbpm_pkg::OFFSET_W'(64'(slot) * bytes_per_frame(st.res)) : '0;
        ans.overwrote = done && over;
    endtask

    task automatic queue_request(input logic [fbpm_pkg::OP_W-1:0] op, input logic ok,
                                 input logic [fbpm_pkg::ID_IN_W-1:0] id);
        pool_request_t r;
        pool_answer_t  unused;
        r.op = op;
        r.fill_ok = ok;
        r.buffer_id = id;
        apply_pool_op(plan_state, r, unused);
        request_queue = {request_queue, r};
    endtask

    // mostly well-formed traffic, unlocks aimed at buffers that will be held
    task automatic draw_request();
        int                           roll;
        logic [fbpm_pkg::ID_IN_W-1:0] id;
        roll = $urandom_range(0, 99);
        id = fbpm_pkg::ID_IN_W'($urandom_range(0, 15));
        if (roll < 42) begin
            queue_request(fbpm_pkg::OP_FILL, $urandom_range(0, 9) != 0, id);
        end else if (roll < 70) begin
            queue_request(fbpm_pkg::OP_LOCK, 1'($urandom_range(0, 1)), id);
        end else if (roll < 94) begin
            if (plan_state.held != 0 && $urandom_range(0, 4) != 0) begin
                while (!plan_state.held[id]) begin
                    id = fbpm_pkg::ID_IN_W'($urandom_range(0, 15));
                end
            end
            queue_request(fbpm_pkg::OP_UNLOCK, 1'($urandom_range(0, 1)), id);
        end else begin
            queue_request(OP_RESERVED, 1'($urandom_range(0, 1)), id);
        end
    endtask

    task automatic write_register(input logic [fbpm_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [fbpm_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_register(plan_state, addr, data);
        apply_register(live_state, addr, data);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (request_queue.size() != 0 || s_valid || due_answers.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_operation <= request_queue[0].op;
                s_fill_ok <= request_queue[0].fill_ok;
                s_buffer_id <= request_queue[0].buffer_id;
                request_queue.delete(0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    // monitor and predictor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_req.op = s_operation;
                taken_req.fill_ok = s_fill_ok;
                taken_req.buffer_id = s_buffer_id;
                apply_pool_op(live_state, taken_req, predicted);
                due_answers = {due_answers, predicted};
            end
            if (m_valid && m_ready) begin
                if (due_answers.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatch_count++;
                end else begin
                    oldest_due = due_answers[0];
                    due_answers.delete(0);
                    if (m_status !== oldest_due.status) begin
                        $error("status: expected %0d, got %0d", oldest_due.status, m_status);
                        mismatch_count++;
                    end
                    if (m_result_buffer !== oldest_due.slot) begin
                        $error("result_buffer: expected %0d, got %0d",
                               oldest_due.slot, m_result_buffer);
                        mismatch_count++;
                    end
                    if (m_buffer_offset !== oldest_due.offset) begin
                        $error("buffer_offset: expected %0d, got %0d",
                               oldest_due.offset, m_buffer_offset);
                        mismatch_count++;
                    end
                    if (m_overwrote !== oldest_due.overwrote) begin
                        $error("overwrote: expected %0d, got %0d",
                               oldest_due.overwrote, m_overwrote);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned count_plan[PHASES];
        int unsigned res_plan[PHASES];
        int unsigned count_val;
        int unsigned res_val;

        count_plan = '{16, 31, 4, 2, 0, 5, 16, 9};
        res_plan = '{2, 1, 4, 3, 0, 6, 7, 26};
        plan_state = '0;
        plan_state.frame_cnt = 5'd3;
        plan_state.res = fbpm_pkg::RES_1080P;
        refill_lists(plan_state);
        live_state = plan_state;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // three buffers at 1080p
        queue_request(fbpm_pkg::OP_LOCK, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b0, 4'd0);
        queue_request(OP_RESERVED, 1'b1, 4'd15);
        queue_request(fbpm_pkg::OP_FILL, 1'b0, 4'd0);
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd15);
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd7);
        queue_request(fbpm_pkg::OP_FILL, 1'b0, 4'd0);
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_LOCK, 1'b0, 4'd0);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b0, 4'd15);
        queue_request(fbpm_pkg::OP_LOCK, 1'b1, 4'd15);
        queue_request(fbpm_pkg::OP_LOCK, 1'b0, 4'd8);
        queue_request(fbpm_pkg::OP_LOCK, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b0, 4'd2);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b1, 4'd1);
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd0);
        wait_drained();

        // single buffer at 8K, one ready and nothing free drops the frame
        write_register(fbpm_pkg::CFG_FRAME_COUNT, 5'd0);
        write_register(fbpm_pkg::CFG_RESOLUTION, fbpm_pkg::CFG_DATA_W'(fbpm_pkg::RES_8K));
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_FILL, 1'b1, 4'd0);
        queue_request(fbpm_pkg::OP_LOCK, 1'b0, 4'd0);
        queue_request(fbpm_pkg::OP_UNLOCK, 1'b0, 4'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase < 3) begin
                send_idle_pct = 25;
                recv_stall_pct = 50;
            end else if (phase < 6) begin
                send_idle_pct = 50;
                recv_stall_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            count_val = (phase == 5) ? $urandom_range(0, 31) : count_plan[phase];
            res_val = (phase == 5) ? $urandom_range(0, 31) : res_plan[phase];
            write_register(fbpm_pkg::CFG_FRAME_COUNT, fbpm_pkg::CFG_DATA_W'(count_val));
            write_register(fbpm_pkg::CFG_RESOLUTION, fbpm_pkg::CFG_DATA_W'(res_val));
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                draw_request();
            end
        end

        wait_drained();
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
